// ===== hdl/php_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// php_pkg
// Shared types, codes and helpers for the packet header parser.
// ----------------------------------------------------------------------------
package php_pkg;

  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 144;

  localparam logic [15:0] POS_MAX     = 16'hFFFF;
  localparam logic [15:0] ETH_HDR_LEN = 16'd14;
  localparam logic [5:0]  IP_MIN_HLEN = 6'd20;
  localparam logic [3:0]  IP_MIN_IHL  = 4'd5;

  localparam logic [15:0] ETYPE_ARP  = 16'h0806;
  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ARP_OP_REQ = 16'h0001;
  localparam logic [15:0] ARP_OP_REP = 16'h0002;
  localparam logic [7:0]  IP_PROTO_ICMP = 8'h01;
  localparam logic [7:0]  IP_PROTO_TCP  = 8'h06;
  localparam logic [7:0]  IP_PROTO_UDP  = 8'h11;
  localparam logic [7:0]  ICMP_ECHO_REQ = 8'h08;
  localparam logic [7:0]  ICMP_ECHO_REP = 8'h00;

  localparam logic [1:0] FRAME_ARP   = 2'd0;
  localparam logic [1:0] FRAME_IPV4  = 2'd1;
  localparam logic [1:0] FRAME_OTHER = 2'd2;

  localparam logic [1:0] PROTO_ICMP  = 2'd0;
  localparam logic [1:0] PROTO_TCP   = 2'd1;
  localparam logic [1:0] PROTO_UDP   = 2'd2;
  localparam logic [1:0] PROTO_OTHER = 2'd3;

  localparam logic [1:0] SUB_REQUEST = 2'd0;
  localparam logic [1:0] SUB_REPLY   = 2'd1;
  localparam logic [1:0] SUB_UNKNOWN = 2'd2;

  typedef struct packed {
    logic [15:0] pos;
    logic [7:0]  held;
    logic [1:0]  frame_kind;
    logic [1:0]  proto_kind;
    logic [3:0]  ihl;
    logic [15:0] total_len;
    logic [15:0] hdr_sum;
    logic [15:0] seg_sum;
    logic [15:0] addr_sum;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [7:0]  ttl;
    logic [7:0]  tos;
    logic [15:0] window;
    logic [2:0]  tcp_ctl;
    logic [1:0]  sub_kind;
  } php_state_t;

  localparam php_state_t STATE_RESET = '{
    pos: '0, held: '0, frame_kind: FRAME_ARP, proto_kind: PROTO_OTHER, ihl: '0,
    total_len: '0, hdr_sum: '0, seg_sum: '0, addr_sum: '0, src_ip: '0, dst_ip: '0,
    sport: '0, dport: '0, ttl: '0, tos: '0, window: '0, tcp_ctl: '0,
    sub_kind: SUB_REQUEST
  };

  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    begin
      s = {1'b0, a} + {1'b0, b};
      oc_add = s[15:0] + {15'd0, s[16]};
    end
  endfunction

  function automatic logic [5:0] ip_hlen(input logic [3:0] ihl);
    begin
      ip_hlen = (ihl < IP_MIN_IHL) ? IP_MIN_HLEN : {ihl, 2'b00};
    end
  endfunction

endpackage
`default_nettype wire

// ===== hdl/php_field_capture.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// php_field_capture
// Per-frame parse state: byte position, captured header fields and running
// ones-complement sums, updated by one frame byte per strobe.
// ----------------------------------------------------------------------------
module php_field_capture
  import php_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       en_i,
  input  wire logic [7:0] byte_i,
  input  wire logic       last_i,
  output php_state_t      upd_o
);

  php_state_t st_q, st_d, upd;

  always_comb begin
    logic [15:0] p;
    logic [15:0] k;
    logic [15:0] t;
    logic [15:0] seg_len;
    logic [15:0] word;
    logic [3:0]  ihl_eff;
    logic [5:0]  hlen;
    p       = st_q.pos;
    k       = p - ETH_HDR_LEN;
    ihl_eff = (k == 16'd0) ? byte_i[3:0] : st_q.ihl;
    hlen    = ip_hlen(ihl_eff);
    t       = k - {10'd0, hlen};
    seg_len = st_q.total_len - {10'd0, hlen};
    word    = k[0] ? {8'd0, byte_i} : {byte_i, 8'd0};
    upd     = st_q;
    if (en_i && (p != POS_MAX)) begin
      upd.pos = p + 16'd1;
      if (p == 16'd12) upd.held = byte_i;
      if (p == 16'd13) begin
        if ({st_q.held, byte_i} == ETYPE_ARP) upd.frame_kind = FRAME_ARP;
        else if ({st_q.held, byte_i} == ETYPE_IPV4) upd.frame_kind = FRAME_IPV4;
        else upd.frame_kind = FRAME_OTHER;
      end
      if (p >= ETH_HDR_LEN) begin
        if (st_q.frame_kind == FRAME_ARP) begin
          if (p == 16'd20) upd.held = byte_i;
          if (p == 16'd21) begin
            if ({st_q.held, byte_i} == ARP_OP_REQ) upd.sub_kind = SUB_REQUEST;
            else if ({st_q.held, byte_i} == ARP_OP_REP) upd.sub_kind = SUB_REPLY;
            else upd.sub_kind = SUB_UNKNOWN;
          end
          if (p >= 16'd28 && p <= 16'd31) upd.src_ip = {st_q.src_ip[23:0], byte_i};
          if (p >= 16'd38 && p <= 16'd41) upd.dst_ip = {st_q.dst_ip[23:0], byte_i};
        end else if (st_q.frame_kind == FRAME_IPV4) begin
          if (k == 16'd0) upd.ihl = byte_i[3:0];
          if (k == 16'd1) upd.tos = byte_i;
          if (k == 16'd2) upd.held = byte_i;
          if (k == 16'd3) upd.total_len = {st_q.held, byte_i};
          if (k == 16'd8) upd.ttl = byte_i;
          if (k == 16'd9) begin
            if (byte_i == IP_PROTO_ICMP) upd.proto_kind = PROTO_ICMP;
            else if (byte_i == IP_PROTO_TCP) upd.proto_kind = PROTO_TCP;
            else if (byte_i == IP_PROTO_UDP) upd.proto_kind = PROTO_UDP;
            else upd.proto_kind = PROTO_OTHER;
          end
          if (k >= 16'd12 && k <= 16'd15) upd.src_ip = {st_q.src_ip[23:0], byte_i};
          if (k >= 16'd16 && k <= 16'd19) upd.dst_ip = {st_q.dst_ip[23:0], byte_i};
          if (k >= 16'd12 && k <= 16'd19) upd.addr_sum = oc_add(st_q.addr_sum, word);
          if (ihl_eff >= IP_MIN_IHL && k < {10'd0, ihl_eff, 2'b00})
            upd.hdr_sum = oc_add(st_q.hdr_sum, word);
          if (k >= {10'd0, hlen}) begin
            case (st_q.proto_kind)
              PROTO_ICMP: begin
                if (t == 16'd0) begin
                  if (byte_i == ICMP_ECHO_REQ) upd.sub_kind = SUB_REQUEST;
                  else if (byte_i == ICMP_ECHO_REP) upd.sub_kind = SUB_REPLY;
                  else upd.sub_kind = SUB_UNKNOWN;
                end
              end
              PROTO_TCP: begin
                if (t < 16'd4) begin
                  if (t[1]) upd.dport = {st_q.dport[7:0], byte_i};
                  else upd.sport = {st_q.sport[7:0], byte_i};
                end
                if (t == 16'd13) upd.tcp_ctl = byte_i[2:0];
                if (t == 16'd14 || t == 16'd15) upd.window = {st_q.window[7:0], byte_i};
                if (st_q.total_len >= {10'd0, hlen} && t < seg_len)
                  upd.seg_sum = oc_add(st_q.seg_sum, t[0] ? {8'd0, byte_i} : {byte_i, 8'd0});
              end
              PROTO_UDP: begin
                if (t < 16'd4) begin
                  if (t[1]) upd.dport = {st_q.dport[7:0], byte_i};
                  else upd.sport = {st_q.sport[7:0], byte_i};
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
    end
  end

  always_comb begin
    st_d = upd;
    if (en_i && last_i) st_d = STATE_RESET;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= STATE_RESET;
    end else begin
      st_q <= st_d;
    end
  end

  assign upd_o = upd;

endmodule
`default_nettype wire

// ===== hdl/php_summary.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// php_summary
// Frame summary: checksum verdicts and packing of the result word from the
// parse state after the final byte.
// ----------------------------------------------------------------------------
module php_summary
  import php_pkg::*;
(
  input  wire php_state_t               st_i,
  output logic [OUT_TDATA_W-1:0]        tdata_o
);

  logic [5:0]  hlen;
  logic [15:0] seg_len;
  logic [17:0] sum_wide;
  logic [16:0] sum_fold;
  logic [15:0] seg_total;
  logic        ipv4;
  logic        hdr_ok;
  logic        tcp_ok;
  logic [1:0]  flags;

  assign hlen    = ip_hlen(st_i.ihl);
  assign seg_len = st_i.total_len - {10'd0, hlen};
  assign ipv4    = (st_i.frame_kind == FRAME_IPV4);

  assign sum_wide  = {2'd0, st_i.seg_sum} + {2'd0, st_i.addr_sum}
                   + {10'd0, IP_PROTO_TCP} + {2'd0, seg_len};
  assign sum_fold  = {1'b0, sum_wide[15:0]} + {15'd0, sum_wide[17:16]};
  assign seg_total = sum_fold[15:0] + {15'd0, sum_fold[16]};

  assign hdr_ok = ipv4 && (st_i.ihl >= IP_MIN_IHL)
               && (st_i.pos >= (ETH_HDR_LEN + {10'd0, hlen}))
               && (st_i.hdr_sum == 16'hFFFF);
  assign tcp_ok = ipv4 && (st_i.proto_kind == PROTO_TCP)
               && (st_i.total_len >= {10'd0, hlen})
               && ({1'b0, st_i.pos} >= ({1'b0, ETH_HDR_LEN} + {1'b0, st_i.total_len}))
               && (seg_total == 16'hFFFF);
  assign flags  = {tcp_ok, hdr_ok};

  assign tdata_o = {5'd0, st_i.window, st_i.tcp_ctl, st_i.dport, st_i.sport,
                    st_i.dst_ip, st_i.src_ip, flags, st_i.tos, st_i.ttl,
                    st_i.sub_kind, st_i.proto_kind, st_i.frame_kind};

endmodule
`default_nettype wire

// ===== hdl/packet_header_parser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// packet_header_parser
// Ethernet / ARP / IPv4 / TCP / UDP / ICMP header parser, one byte per clock when not stalled.
//
// The slave stream carries an Ethernet frame from the destination MAC on,
// one byte per request, with tlast on the final byte. The master stream
// gives one summary per frame, presented after the tlast byte: class of
// frame and protocol, ARP/ICMP kind, TTL, TOS, checksum verdicts, addresses,
// ports, TCP flags and window.
// A byte taken lands in the input register and is parsed as it leaves it;
// the summary of a frame is registered as its tlast byte leaves. One byte
// is accepted every cycle unless stalled, including across frame
// boundaries; the parse state is cleared as the tlast byte is consumed.
// The only stall is a tlast byte waiting while the previous summary has
// not yet been taken: input bytes then back up in the input register and
// tready falls. Bytes not marked tlast always move on.
// Reset clears the parse state and both valid flags.
// ----------------------------------------------------------------------------
module packet_header_parser
  import php_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  wire logic                   s_axis_tlast_i,
  output logic                        m_axis_tvalid_o,
  input  wire logic                   m_axis_tready_i,
  // [1:0] frame_class, [3:2] proto_class, [5:4] sub_kind, [13:6] time_to_live,
  // [21:14] type_of_service, [23:22] checksum_flags, [55:24] source_ip,
  // [87:56] dest_ip, [103:88] source_port, [119:104] dest_port,
  // [122:120] tcp_control, [138:123] window_size
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata_o
);

  logic                   in_vld_q, in_vld_d;
  logic [7:0]             in_byte_q;
  logic                   in_last_q;
  logic                   s_accept;
  logic                   adv;
  logic                   out_vld_q, out_vld_d;
  logic [OUT_TDATA_W-1:0] out_data_q;
  logic [OUT_TDATA_W-1:0] summary;
  php_state_t             upd;

  assign adv             = in_vld_q && (!in_last_q || !out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_vld_q || adv;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (s_accept) in_vld_d = 1'b1;
    else if (adv) in_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  php_field_capture u_capture (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .byte_i (in_byte_q),
    .last_i (in_last_q),
    .upd_o  (upd)
  );

  php_summary u_summary (
    .st_i    (upd),
    .tdata_o (summary)
  );

  always_comb begin
    out_vld_d = out_vld_q;
    if (adv && in_last_q) out_vld_d = 1'b1;
    else if (m_axis_tready_i) out_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_last_q) out_data_q <= summary;
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;

  a_out_from_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(adv && in_last_q))
    else $error("summary without a consumed tlast byte");

  a_hold_on_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !adv) |=> (in_vld_q && $stable(in_byte_q) && $stable(in_last_q)))
    else $error("input register lost a stalled byte");

  a_tcp_ok_class : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_data_q[23]) |->
      (out_data_q[1:0] == FRAME_IPV4 && out_data_q[3:2] == PROTO_TCP))
    else $error("TCP checksum pass on a non-TCP frame");

  a_frame_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_data_q[1:0] != 2'd3))
    else $error("invalid frame class");

endmodule
`default_nettype wire
